// ===== rtl/core/olisr_pkg.sv =====
// Package for the ordered list block: sizes, operation and status codes,
// and the control word that the top level hands to every list cell.
// No dependencies.
package olisr_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;
	localparam int FILL_W  = $clog2(DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_SEARCH = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

// ===== rtl/core/olisr_cell.sv =====
// One list cell: holds one entry, compares it with the operand word, and
// shifts toward the back on insert or toward the front on remove.
// Depends on olisr_pkg.
module olisr_cell (
	input  logic                      clk,
	input  olisr_pkg::cell_ctl_t      ctl,
	input  logic [olisr_pkg::DATA_W-1:0] value,
	input  logic                      held,
	input  logic                      match_in,
	input  logic [olisr_pkg::DATA_W-1:0] from_front,
	input  logic [olisr_pkg::DATA_W-1:0] from_back,
	output logic                      match_out,
	output logic                      first,
	output logic [olisr_pkg::DATA_W-1:0] data_q
);
	import olisr_pkg::*;

	logic hit;

	assign hit       = held && (data_q == value);
	assign first     = hit && !match_in;
	assign match_out = match_in || hit;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			data_q <= from_front;
		end else if (ctl.rem && match_out) begin
			data_q <= from_back;
		end
	end

endmodule

// ===== rtl/core/ordered_list_insert_search_remove.sv =====
// Top level of the ordered list: a row of olisr_cell instances with the
// operation decode, first-match encoding, fill count and result register.
// Depends on olisr_pkg and olisr_cell.
//
//  channel   handshake        payload
//  command   start / busy     kind, value
//  result    done strobe      status, position, count
//
// All cells compare; an insert that fits or a remove that hits shifts them at
// the accepting edge, and the result appears on the next cycle with done high.
// busy stays low, so a word can be started in every cycle.
// Reset empties the list at once; no clearing pass follows.
// The receiver cannot stall, and done is high for one cycle per accepted word.
module ordered_list_insert_search_remove (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [olisr_pkg::KIND_W-1:0]  kind,
	input  logic signed [olisr_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic [olisr_pkg::STAT_W-1:0]  status,
	output logic [olisr_pkg::POS_W-1:0]   position,
	output logic [olisr_pkg::COUNT_W-1:0] count
);
	import olisr_pkg::*;

	logic [FILL_W-1:0] fill_q;
	logic              done_q;
	status_t           status_q;
	logic [POS_W-1:0]  position_q;
	logic              accept;
	logic              is_ins;
	logic              is_rem;
	logic              full;
	logic              found;
	logic [POS_W-1:0]  match_pos;
	cell_ctl_t         ctl;
	logic [DEPTH:0]    chain;
	logic [DEPTH-1:0]  first;
	logic [DEPTH-1:0]  held;
	logic [DATA_W-1:0] cell_data [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_ins = (kind == KIND_INSERT);
	assign is_rem = (kind == KIND_REMOVE);
	assign full   = (fill_q == FILL_W'(DEPTH));
	assign found  = chain[DEPTH];

	assign ctl.ins = accept && is_ins && !full;
	assign ctl.rem = accept && is_rem && found;

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] front_d;
		logic [DATA_W-1:0] back_d;

		assign held[i] = (FILL_W'(i) < fill_q);

		if (i == 0) begin : g_head
			assign front_d = value;
		end else begin : g_body
			assign front_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign back_d = cell_data[i];
		end else begin : g_inner
			assign back_d = cell_data[i+1];
		end

		olisr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value),
			.held       (held[i]),
			.match_in   (chain[i]),
			.from_front (front_d),
			.from_back  (back_d),
			.match_out  (chain[i+1]),
			.first      (first[i]),
			.data_q     (cell_data[i])
		);
	end

	always_comb begin
		match_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				match_pos = match_pos | POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				fill_q <= fill_q + 1'b1;
			end else if (ctl.rem) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_ins) begin
				status_q   <= full ? ST_FULL : ST_OK;
				position_q <= '0;
			end else begin
				status_q   <= found ? ST_OK : ST_MISS;
				position_q <= found ? match_pos : '0;
			end
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign position = position_q;
	assign count    = COUNT_W'(fill_q);

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count exceeds depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word gave no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == COUNT_W'(DEPTH) && position == '0))
		else $error("dropped insert with list not full");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_MISS) |-> (position == '0))
		else $error("miss reported with nonzero position");

	a_one_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first) && (found == (first != '0)))
		else $error("first-match flags inconsistent");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for ordered_list_insert_search_remove: a short directed table, then random
// insert/remove/search words; results checked against table values or a list model.
// Depends on olisr_pkg and the block's RTL.
module testbench;
	import olisr_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_WORDS = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [KIND_W-1:0] KIND_SEARCH_ALIAS = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

	typedef struct packed {
		status_t st;
		logic [POS_W-1:0] pos;
		logic [COUNT_W-1:0] cnt;
	} outcome_t;

	typedef struct {
		logic [KIND_W-1:0] op;
		logic signed [DATA_W-1:0] val;
		int reps;
		bit typed;
		outcome_t outcome;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [KIND_W-1:0] kind;
	logic signed [DATA_W-1:0] value;
	logic done;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0] position;
	logic [COUNT_W-1:0] count;

	bit word_typed;
	outcome_t word_expect;

	logic signed [DATA_W-1:0] held_values [DEPTH];
	int held_count;
	outcome_t pending_results [$];
	int fail_count;
	int cycle_count;

	ordered_list_insert_search_remove u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.value(value),
		.done(done),
		.status(status),
		.position(position),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Applies one word to the list model and returns the result it should give.
	function automatic outcome_t list_apply(input logic [KIND_W-1:0] op,
			input logic signed [DATA_W-1:0] v);
		outcome_t r;
		int hit;
		int i;
		r.st = ST_OK;
		r.pos = '0;
		hit = -1;
		if (op == KIND_INSERT) begin
			if (held_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				for (i = held_count; i > 0; i--)
					held_values[i] = held_values[i - 1];
				held_values[0] = v;
				held_count++;
			end
		end else begin
			for (i = 0; i < held_count; i++)
				if (hit < 0 && held_values[i] == v)
					hit = i;
			if (hit < 0) begin
				r.st = ST_MISS;
			end else begin
				r.pos = hit[POS_W-1:0];
				if (op == KIND_REMOVE) begin
					for (i = hit; i + 1 < held_count; i++)
						held_values[i] = held_values[i + 1];
					held_count--;
				end
			end
		end
		r.cnt = held_count[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		outcome_t predicted;
		if (arst_n) begin
			if (done === 1'b1) begin
				got.st = status_t'(status);
				got.pos = position;
				got.cnt = count;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("Unexpected result word: status %0d position %0d count %0d",
							status, position, count);
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st || got.pos !== want.pos || got.cnt !== want.cnt) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("Mismatch: expected status %0d position %0d count %0d, got status %0d position %0d count %0d",
								want.st, want.pos, want.cnt, status, position, count);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predicted = list_apply(kind, value);
				pending_results.push_back(word_typed ? word_expect : predicted);
			end
		end
	end

	task automatic idle_cycle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
			input bit typed, input outcome_t e);
		start <= 1'b1;
		kind <= k;
		value <= v;
		word_typed <= typed;
		word_expect <= e;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		plan_row_t plan [];
		outcome_t none;
		logic [KIND_W-1:0] op;
		logic signed [DATA_W-1:0] v;
		int idle_pct;
		int ins_pct;
		int pick;
		int r;
		int n;

		start = 1'b0;
		kind = KIND_INSERT;
		value = '0;
		word_typed = 1'b0;
		word_expect = '0;
		arst_n = 1'b0;
		held_count = 0;
		fail_count = 0;
		cycle_count = 0;
		none = '0;
		for (n = 0; n < DEPTH; n++)
			held_values[n] = '0;

		plan = '{
			'{KIND_SEARCH, 0, 1, 1, '{ST_MISS, 0, 0}},
			'{KIND_REMOVE, 5, 1, 1, '{ST_MISS, 0, 0}},
			'{KIND_INSERT, VAL_MIN, 1, 1, '{ST_OK, 0, 1}},
			'{KIND_INSERT, VAL_MAX, 1, 1, '{ST_OK, 0, 2}},
			'{KIND_SEARCH, VAL_MIN, 1, 1, '{ST_OK, 1, 2}},
			'{KIND_SEARCH_ALIAS, VAL_MAX, 1, 1, '{ST_OK, 0, 2}},
			'{KIND_INSERT, 0, 14, 0, '{ST_OK, 0, 0}},
			'{KIND_INSERT, -1, 1, 1, '{ST_FULL, 0, 16}},
			'{KIND_SEARCH, VAL_MIN, 1, 1, '{ST_OK, 15, 16}},
			'{KIND_REMOVE, VAL_MIN, 1, 1, '{ST_OK, 15, 15}},
			'{KIND_REMOVE, 0, 1, 1, '{ST_OK, 0, 14}},
			'{KIND_SEARCH, VAL_MAX, 1, 1, '{ST_OK, 13, 14}},
			'{KIND_REMOVE, 12345, 1, 1, '{ST_MISS, 0, 14}}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[row])
			for (n = 0; n < plan[row].reps; n++)
				send_word(plan[row].op, plan[row].val, plan[row].typed, plan[row].outcome);

		drain_results();

		for (n = 0; n < RANDOM_WORDS; n++) begin
			// The sender's gaps grow, then vanish, over the three thirds of the run.
			idle_pct = (n * 3 < RANDOM_WORDS) ? 20 : (n * 3 < 2 * RANDOM_WORDS) ? 88 : 0;
			if (n % 500 == 499)
				drain_results();
			while ($urandom_range(0, 99) < idle_pct)
				idle_cycle();

			// Alternate stretches that fill the list and stretches that drain it.
			ins_pct = ((n / 120) % 2 == 0) ? 60 : 25;
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = KIND_INSERT;
			else if (r < ins_pct + (100 - ins_pct) / 2)
				op = KIND_REMOVE;
			else if (r < 97)
				op = KIND_SEARCH;
			else
				op = KIND_SEARCH_ALIAS;

			pick = $urandom_range(0, 9);
			if (held_count > 0 && pick < 5) begin
				v = held_values[$urandom_range(0, held_count - 1)];
			end else if (pick < 8) begin
				case ($urandom_range(0, 6))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = -2;
					3: v = -1;
					4: v = 0;
					5: v = 1;
					default: v = 2;
				endcase
			end else begin
				v = $urandom;
			end
			send_word(op, v, 1'b0, none);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
